// ===== rtl/core/ffa_pkg.sv =====
package ffa_pkg;

   localparam int MEM_UNITS = 1024;
   localparam int WORD_BITS = 32;
   localparam int WORDS = MEM_UNITS / WORD_BITS;
   localparam int WADDR_W = $clog2(WORDS);
   localparam int BIT_W = $clog2(WORD_BITS);
   localparam int ADDR_W = $clog2(MEM_UNITS);
   localparam int SIZE_W = ADDR_W + 1;
   localparam int DEV_W = 3;
   localparam int CNT_W = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_PRINTER_TOTAL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCANNER_TOTAL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODEM_TOTAL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CD_TOTAL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RT_RESERVE = 3'd4;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEARCH,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic latch;
      logic rel_apply;
      logic search_start;
      logic search_run;
      logic upd_read;
      logic upd_run;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic is_release;
      logic alloc_ok;
      logic rel_nonempty;
      logic hit;
      logic last_word;
      logic last_upd;
   } dp_sts_type;

endpackage

// ===== rtl/core/first_fit_memory_resource_allocator.sv =====
// channel   direction  handshake               payload
// req       in         req_valid / req_stall   cmd, realtime_req, size, devices, release_base
// rsp       out        rsp_valid / rsp_stall   granted, base_address, free_units, completed
// csr       in         csr_we                  csr_index, csr_wdata
// one request at a time; a refused allocate or an empty release goes from ST_CHECK to ST_DONE
// an allocate searches the bitmap one 32-bit word per cycle, up to all 32 words,
// then, after the ST_UPD_RD read state, marks its run one word per cycle
// a nonempty release passes ST_UPD_RD, then clears each bitmap word it touches
// synchronous reset gives every unit free at once, no clearing pass
// a result waits in the output register under rsp_stall; the next request is taken meanwhile
module first_fit_memory_resource_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic                          req_realtime_req,
   input  logic [ffa_pkg::SIZE_W-1:0]    req_size_units,
   input  logic [ffa_pkg::DEV_W-1:0]     req_want_printers,
   input  logic [ffa_pkg::DEV_W-1:0]     req_want_scanners,
   input  logic [ffa_pkg::DEV_W-1:0]     req_want_modems,
   input  logic [ffa_pkg::DEV_W-1:0]     req_want_cds,
   input  logic [ffa_pkg::ADDR_W-1:0]    req_release_base,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_granted,
   output logic [ffa_pkg::ADDR_W-1:0]    rsp_base_address,
   output logic [ffa_pkg::SIZE_W-1:0]    rsp_free_units,
   output logic [ffa_pkg::CNT_W-1:0]     rsp_completed,
   input  logic                          csr_we,
   input  logic [ffa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ffa_pkg::SIZE_W-1:0]    csr_wdata
);
   import ffa_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   ffa_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .sts(sts),
      .cmd(cmd)
   );

   ffa_dp u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .sts(sts),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_cmd(req_cmd),
      .req_realtime_req(req_realtime_req),
      .req_size_units(req_size_units),
      .req_want_printers(req_want_printers),
      .req_want_scanners(req_want_scanners),
      .req_want_modems(req_want_modems),
      .req_want_cds(req_want_cds),
      .req_release_base(req_release_base),
      .rsp_granted(rsp_granted),
      .rsp_base_address(rsp_base_address),
      .rsp_free_units(rsp_free_units),
      .rsp_completed(rsp_completed)
   );

endmodule

// ===== rtl/core/ffa_ctrl.sv =====
module ffa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  ffa_pkg::dp_sts_type sts,
   output ffa_pkg::dp_cmd_type cmd
);
   import ffa_pkg::*;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.is_release) state_in = sts.rel_nonempty ? ST_UPD_RD : ST_DONE;
            else state_in = sts.alloc_ok ? ST_SEARCH : ST_DONE;
         end
         ST_SEARCH: begin
            if (sts.hit) state_in = ST_UPD_RD;
            else if (sts.last_word) state_in = ST_DONE;
         end
         ST_UPD_RD: state_in = ST_UPD_WR;
         ST_UPD_WR: begin
            if (sts.last_upd) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.latch = req_valid;
         end
         ST_CHECK: begin
            cmd.rel_apply = sts.is_release;
            cmd.search_start = !sts.is_release && sts.alloc_ok;
         end
         ST_SEARCH: cmd.search_run = 1'b1;
         ST_UPD_RD: cmd.upd_read = 1'b1;
         ST_UPD_WR: cmd.upd_run = 1'b1;
         ST_DONE: cmd.rsp_load = out_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff) else $error("result not presented");
   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(!rsp_stall)) else $error("result dropped");
   a_search_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && sts.last_word && !sts.hit) |=> state_ff == ST_DONE)
      else $error("search overran bitmap");

endmodule

// ===== rtl/core/ffa_dp.sv =====
module ffa_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  ffa_pkg::dp_cmd_type                cmd,
   output ffa_pkg::dp_sts_type                sts,
   input  logic                               csr_we,
   input  logic [ffa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ffa_pkg::SIZE_W-1:0]         csr_wdata,
   input  logic                               req_cmd,
   input  logic                               req_realtime_req,
   input  logic [ffa_pkg::SIZE_W-1:0]         req_size_units,
   input  logic [ffa_pkg::DEV_W-1:0]          req_want_printers,
   input  logic [ffa_pkg::DEV_W-1:0]          req_want_scanners,
   input  logic [ffa_pkg::DEV_W-1:0]          req_want_modems,
   input  logic [ffa_pkg::DEV_W-1:0]          req_want_cds,
   input  logic [ffa_pkg::ADDR_W-1:0]         req_release_base,
   output logic                               rsp_granted,
   output logic [ffa_pkg::ADDR_W-1:0]         rsp_base_address,
   output logic [ffa_pkg::SIZE_W-1:0]         rsp_free_units,
   output logic [ffa_pkg::CNT_W-1:0]          rsp_completed
);
   import ffa_pkg::*;

   logic [DEV_W-1:0] tot_ff [4];
   logic [SIZE_W-1:0] reserve_ff;
   logic [DEV_W-1:0] use_ff [4];
   logic [SIZE_W-1:0] free_ff;
   logic [CNT_W-1:0] count_ff;

   logic op_ff, rt_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [DEV_W-1:0] want_ff [4];
   logic [ADDR_W-1:0] rbase_ff;

   logic res_granted_ff;
   logic [ADDR_W-1:0] res_base_ff;

   logic [WORD_BITS-1:0] mem [WORDS];
   logic [WORDS-1:0] vld_ff;
   logic [WORD_BITS-1:0] rd_ff;
   logic rd_vld_ff;
   logic [WORD_BITS-1:0] word;

   logic [WADDR_W-1:0] cnt_ff;
   logic [SIZE_W-1:0] carry_ff;
   logic [ADDR_W-1:0] lo_ff, hi_ff;
   logic set_ff;
   logic [WADDR_W-1:0] wa_ff;

   logic dev_ok, res_ok;
   logic [SIZE_W-1:0] run;
   logic [BIT_W:0] last_set [WORD_BITS];
   logic [SIZE_W-1:0] run_at [WORD_BITS];
   logic found;
   logic [BIT_W-1:0] kpos;
   logic [ADDR_W-1:0] end_addr, start_addr;
   logic [SIZE_W:0] rel_sum;
   logic [ADDR_W-1:0] rel_hi;
   logic [WORD_BITS-1:0] upd_mask, wr_word;
   logic [SIZE_W:0] free_sum;
   logic rd_en;
   logic [WADDR_W-1:0] rd_addr;

   assign word = rd_vld_ff ? rd_ff : '0;

   always_comb begin
      dev_ok = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if ({1'b0, use_ff[i]} + {1'b0, want_ff[i]} > {1'b0, tot_ff[i]}) dev_ok = 1'b0;
      end
      res_ok = {1'b0, free_ff} >= {1'b0, size_ff} + {1'b0, reserve_ff};
   end

   // free run ending at each bit, all bits in parallel
   always_comb begin
      for (int k = 0; k < WORD_BITS; k++) begin
         last_set[k] = '0;
         for (int j = 0; j <= k; j++) begin
            if (word[j]) last_set[k] = (BIT_W+1)'(j + 1);
         end
         if (last_set[k] == '0) run_at[k] = carry_ff + SIZE_W'(k + 1);
         else run_at[k] = SIZE_W'(k + 1) - {{(SIZE_W-BIT_W-1){1'b0}}, last_set[k]};
      end
      found = 1'b0;
      kpos = '0;
      for (int k = WORD_BITS - 1; k >= 0; k--) begin
         if (run_at[k] >= size_ff) begin
            found = 1'b1;
            kpos = BIT_W'(k);
         end
      end
      run = run_at[WORD_BITS-1];
   end

   assign end_addr = {cnt_ff, kpos};
   assign start_addr = end_addr + ADDR_W'(1) - size_ff[ADDR_W-1:0];
   assign rel_sum = {2'b00, rbase_ff} + {1'b0, size_ff} - (SIZE_W+1)'(1);
   assign rel_hi = (rel_sum > (SIZE_W+1)'(MEM_UNITS - 1)) ? ADDR_W'(MEM_UNITS - 1)
                                                          : rel_sum[ADDR_W-1:0];
   assign free_sum = {1'b0, free_ff} + {1'b0, size_ff};

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         upd_mask[b] = ({wa_ff, BIT_W'(b)} >= lo_ff) && ({wa_ff, BIT_W'(b)} <= hi_ff);
      end
      wr_word = set_ff ? (word | upd_mask) : (word & ~upd_mask);
   end

   assign sts.is_release = (op_ff == CMD_RELEASE);
   assign sts.alloc_ok = (rt_ff || (dev_ok && res_ok)) && (size_ff != '0);
   assign sts.rel_nonempty = (size_ff != '0);
   assign sts.hit = found;
   assign sts.last_word = (cnt_ff == WADDR_W'(WORDS - 1));
   assign sts.last_upd = (wa_ff == hi_ff[ADDR_W-1:BIT_W]);

   always_comb begin
      rd_en = cmd.search_start || cmd.search_run || cmd.upd_read || cmd.upd_run;
      rd_addr = wa_ff;
      if (cmd.search_start) rd_addr = '0;
      else if (cmd.search_run) rd_addr = cnt_ff + 1'b1;
      else if (cmd.upd_run) rd_addr = wa_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
      if (cmd.upd_run) begin
         mem[wa_ff] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (rd_en) rd_vld_ff <= vld_ff[rd_addr];
         if (cmd.upd_run) vld_ff[wa_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tot_ff[0] <= 3'd2;
         tot_ff[1] <= 3'd1;
         tot_ff[2] <= 3'd1;
         tot_ff[3] <= 3'd2;
         reserve_ff <= SIZE_W'(64);
         for (int i = 0; i < 4; i++) use_ff[i] <= '0;
         free_ff <= SIZE_W'(MEM_UNITS);
         count_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PRINTER_TOTAL: tot_ff[0] <= csr_wdata[DEV_W-1:0];
               CSR_SCANNER_TOTAL: tot_ff[1] <= csr_wdata[DEV_W-1:0];
               CSR_MODEM_TOTAL: tot_ff[2] <= csr_wdata[DEV_W-1:0];
               CSR_CD_TOTAL: tot_ff[3] <= csr_wdata[DEV_W-1:0];
               CSR_RT_RESERVE: reserve_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.rel_apply) begin
            if (!rt_ff) begin
               for (int i = 0; i < 4; i++) begin
                  use_ff[i] <= (use_ff[i] > want_ff[i]) ? use_ff[i] - want_ff[i] : '0;
               end
            end
            free_ff <= (free_sum > (SIZE_W+1)'(MEM_UNITS)) ? SIZE_W'(MEM_UNITS)
                                                          : free_sum[SIZE_W-1:0];
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.search_run && found) begin
            free_ff <= free_ff - size_ff;
            if (!rt_ff) begin
               for (int i = 0; i < 4; i++) use_ff[i] <= use_ff[i] + want_ff[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff <= req_cmd;
         rt_ff <= req_realtime_req;
         size_ff <= req_size_units;
         want_ff[0] <= req_want_printers;
         want_ff[1] <= req_want_scanners;
         want_ff[2] <= req_want_modems;
         want_ff[3] <= req_want_cds;
         rbase_ff <= req_release_base;
         res_granted_ff <= 1'b0;
         res_base_ff <= '0;
      end
      if (cmd.rel_apply) begin
         res_granted_ff <= 1'b1;
         lo_ff <= rbase_ff;
         hi_ff <= rel_hi;
         set_ff <= 1'b0;
         wa_ff <= rbase_ff[ADDR_W-1:BIT_W];
      end
      if (cmd.search_start) begin
         cnt_ff <= '0;
         carry_ff <= '0;
      end
      if (cmd.search_run) begin
         cnt_ff <= cnt_ff + 1'b1;
         carry_ff <= run;
         if (found) begin
            res_granted_ff <= 1'b1;
            res_base_ff <= start_addr;
            lo_ff <= start_addr;
            hi_ff <= end_addr;
            set_ff <= 1'b1;
            wa_ff <= start_addr[ADDR_W-1:BIT_W];
         end
      end
      if (cmd.upd_run) begin
         wa_ff <= wa_ff + 1'b1;
      end
      if (cmd.rsp_load) begin
         rsp_granted <= res_granted_ff;
         rsp_base_address <= res_base_ff;
         rsp_free_units <= free_ff;
         rsp_completed <= count_ff;
      end
   end

   a_free_range: assert property (@(posedge clock) disable iff (reset)
      free_ff <= SIZE_W'(MEM_UNITS)) else $error("free count out of range");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import ffa_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 100;

   typedef struct {
      logic              cmd;
      logic              rt;
      logic [SIZE_W-1:0] size;
      logic [DEV_W-1:0]  dev [4];
      logic [ADDR_W-1:0] rbase;
   } alloc_req_type;

   typedef struct {
      logic              granted;
      logic [ADDR_W-1:0] base;
      logic [SIZE_W-1:0] free_units;
      logic [CNT_W-1:0]  completed;
   } alloc_rsp_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_cmd;
   logic              req_realtime_req;
   logic [SIZE_W-1:0] req_size_units;
   logic [DEV_W-1:0]  req_want_printers;
   logic [DEV_W-1:0]  req_want_scanners;
   logic [DEV_W-1:0]  req_want_modems;
   logic [DEV_W-1:0]  req_want_cds;
   logic [ADDR_W-1:0] req_release_base;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_granted;
   logic [ADDR_W-1:0] rsp_base_address;
   logic [SIZE_W-1:0] rsp_free_units;
   logic [CNT_W-1:0]  rsp_completed;
   logic              csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SIZE_W-1:0] csr_wdata;

   // allocator shadow state
   logic       unit_map [MEM_UNITS];
   int         units_left;
   int         dev_busy [4];
   int         dev_total [4];
   int         rt_reserve;
   int         release_cnt;

   alloc_rsp_type expected_q [$];
   alloc_req_type live_q [$];
   int         errors;
   int         mismatches;
   int         cycles;
   int         stall_pct;
   int         hold_seq;
   int         hold_seen;
   int         hold_left;
   int         burst_left;

   first_fit_memory_resource_allocator u_top (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic alloc_rsp_type compute_grant(alloc_req_type r);
      alloc_rsp_type o;
      bit         ok;
      int         run;
      int         k;
      o.granted = 1'b0;
      o.base = '0;
      if (r.cmd == CMD_ALLOC) begin
         ok = 1'b1;
         if (!r.rt) begin
            for (k = 0; k < 4; k++)
               if (dev_busy[k] + int'(r.dev[k]) > dev_total[k]) ok = 1'b0;
            if (units_left - int'(r.size) < rt_reserve) ok = 1'b0;
         end
         if (ok && r.size != 0) begin
            run = 0;
            for (int i = 0; i < MEM_UNITS; i++) begin
               if (!unit_map[i]) begin
                  run++;
                  if (run == int'(r.size)) begin
                     for (int j = i + 1 - run; j <= i; j++) unit_map[j] = 1'b1;
                     units_left = (units_left > run) ? units_left - run : 0;
                     if (!r.rt)
                        for (k = 0; k < 4; k++) dev_busy[k] += int'(r.dev[k]);
                     o.granted = 1'b1;
                     o.base = ADDR_W'(i + 1 - run);
                     break;
                  end
               end else begin
                  run = 0;
               end
            end
         end
      end else begin
         if (!r.rt)
            for (k = 0; k < 4; k++)
               dev_busy[k] = (dev_busy[k] > int'(r.dev[k])) ? dev_busy[k] - int'(r.dev[k]) : 0;
         for (int j = 0; j < int'(r.size); j++)
            if (int'(r.rbase) + j < MEM_UNITS) unit_map[int'(r.rbase) + j] = 1'b0;
         units_left += int'(r.size);
         if (units_left > MEM_UNITS) units_left = MEM_UNITS;
         release_cnt = (release_cnt + 1) & 16'hFFFF;
         o.granted = 1'b1;
      end
      o.free_units = SIZE_W'(units_left);
      o.completed = CNT_W'(release_cnt);
      return o;
   endfunction

   // drive one request and wait for it to be taken
   task automatic send_request(alloc_req_type r);
      alloc_rsp_type e;
      req_valid <= 1'b1;
      req_cmd <= r.cmd;
      req_realtime_req <= r.rt;
      req_size_units <= r.size;
      req_want_printers <= r.dev[0];
      req_want_scanners <= r.dev[1];
      req_want_modems <= r.dev[2];
      req_want_cds <= r.dev[3];
      req_release_base <= r.rbase;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      e = compute_grant(r);
      expected_q.push_back(e);
      if (r.cmd == CMD_ALLOC && e.granted) begin
         r.cmd = CMD_RELEASE;
         r.rbase = e.base;
         live_q.push_back(r);
      end
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = $urandom_range(0, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PRINTER_TOTAL: dev_total[0] = int'(val[DEV_W-1:0]);
         CSR_SCANNER_TOTAL: dev_total[1] = int'(val[DEV_W-1:0]);
         CSR_MODEM_TOTAL:   dev_total[2] = int'(val[DEV_W-1:0]);
         CSR_CD_TOTAL:      dev_total[3] = int'(val[DEV_W-1:0]);
         CSR_RT_RESERVE:    rt_reserve = int'(val);
         default: ;
      endcase
   endtask

   task automatic set_limits(int p, int s, int m, int c, int rsv);
      wait_idle();
      write_csr(CSR_PRINTER_TOTAL, SIZE_W'(p));
      write_csr(CSR_SCANNER_TOTAL, SIZE_W'(s));
      write_csr(CSR_MODEM_TOTAL, SIZE_W'(m));
      write_csr(CSR_CD_TOTAL, SIZE_W'(c));
      write_csr(CSR_RT_RESERVE, SIZE_W'(rsv));
   endtask

   function automatic alloc_req_type make_req(logic cmd, logic rt, int size,
                                              int p, int s, int m, int c, int rbase);
      alloc_req_type r;
      r.cmd = cmd;
      r.rt = rt;
      r.size = SIZE_W'(size);
      r.dev[0] = DEV_W'(p);
      r.dev[1] = DEV_W'(s);
      r.dev[2] = DEV_W'(m);
      r.dev[3] = DEV_W'(c);
      r.rbase = ADDR_W'(rbase);
      return r;
   endfunction

   function automatic alloc_req_type random_request();
      alloc_req_type r;
      int         pick;
      int         idx;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         r = make_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 2047),
                      $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7),
                      $urandom_range(0, 7), $urandom_range(0, 1023));
      end else if (live_q.size() != 0 && (pick < 55 || units_left < 200)) begin
         idx = $urandom_range(0, live_q.size() - 1);
         r = live_q[idx];
         live_q.delete(idx);
      end else begin
         r = make_req(CMD_ALLOC, $urandom_range(0, 3) == 0,
                      ($urandom_range(0, 19) == 0) ? $urandom_range(1, 1024)
                                                    : $urandom_range(1, 64),
                      $urandom_range(0, 2), $urandom_range(0, 1), $urandom_range(0, 1),
                      $urandom_range(0, 2), $urandom_range(0, 1023));
      end
      return r;
   endfunction

   // receiver stall pattern and long hold-off
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      alloc_rsp_type e;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** first_fit_memory_resource_allocator: FAILED **");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            errors++;
            if (mismatches++ < 10) $display("unexpected response at cycle %0d", cycles);
         end else begin
            e = expected_q.pop_front();
            if (rsp_granted !== e.granted || rsp_base_address !== e.base ||
                rsp_free_units !== e.free_units || rsp_completed !== e.completed) begin
               errors++;
               if (mismatches++ < 10)
                  $display({"mismatch cycle %0d: exp g=%0d b=%0d f=%0d c=%0d",
                            " got g=%0d b=%0d f=%0d c=%0d"},
                           cycles, e.granted, e.base, e.free_units, e.completed,
                           rsp_granted, rsp_base_address, rsp_free_units, rsp_completed);
            end
         end
      end
   end

   task automatic test_directed();
      send_request(make_req(CMD_ALLOC, 1'b0, 0, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_ALLOC, 1'b1, 1, 7, 7, 7, 7, 1023));
      send_request(make_req(CMD_ALLOC, 1'b1, 1024, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_ALLOC, 1'b1, 2047, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_ALLOC, 1'b0, 4, 7, 0, 0, 0, 0));
      send_request(make_req(CMD_ALLOC, 1'b0, 4, 2, 1, 1, 2, 0));
      send_request(make_req(CMD_ALLOC, 1'b0, 1, 1, 0, 0, 0, 0));
      send_request(make_req(CMD_ALLOC, 1'b0, 1000, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_ALLOC, 1'b0, 955, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_ALLOC, 1'b1, 959, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_ALLOC, 1'b1, 60, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_RELEASE, 1'b0, 1, 7, 7, 7, 7, 0));
      send_request(make_req(CMD_RELEASE, 1'b1, 16, 7, 7, 7, 7, 1023));
      send_request(make_req(CMD_ALLOC, 1'b1, 1, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_RELEASE, 1'b0, 2047, 0, 0, 0, 0, 512));
      send_request(make_req(CMD_RELEASE, 1'b1, 0, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_RELEASE, 1'b0, 1024, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_ALLOC, 1'b0, 1024, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_ALLOC, 1'b1, 1024, 0, 0, 0, 0, 0));
      send_request(make_req(CMD_RELEASE, 1'b1, 1024, 0, 0, 0, 0, 0));
      live_q.delete();
   endtask

   task automatic test_random(int n);
      repeat (n) begin
         send_request(random_request());
         pace_sender();
      end
   endtask

   task automatic test_limits();
      set_limits(0, 0, 0, 0, 0);
      stall_pct = 0;
      test_random(60);
      set_limits(7, 7, 7, 7, 1024);
      stall_pct = 30;
      test_random(60);
      set_limits(2047, 1, 0, 7, 2047);
      test_random(40);
      set_limits(1, 1, 1, 1, 8);
      stall_pct = 50;
      test_random(60);
      set_limits(7, 7, 7, 7, 0);
   endtask

   task automatic test_backpressure();
      wait_idle();
      hold_seq++;
      repeat (25) send_request(random_request());
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_ALLOC;
      req_realtime_req = 1'b0;
      req_size_units = '0;
      req_want_printers = '0;
      req_want_scanners = '0;
      req_want_modems = '0;
      req_want_cds = '0;
      req_release_base = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      errors = 0;
      mismatches = 0;
      cycles = 0;
      stall_pct = 0;
      hold_seq = 0;
      hold_seen = 0;
      hold_left = 0;
      burst_left = 0;
      for (int i = 0; i < MEM_UNITS; i++) unit_map[i] = 1'b0;
      units_left = MEM_UNITS;
      dev_busy = '{0, 0, 0, 0};
      dev_total = '{2, 1, 1, 2};
      rt_reserve = 64;
      release_cnt = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_limits();
      test_backpressure();
      stall_pct = 20;
      test_random(400);
      wait_idle();
      if (errors == 0 && expected_q.size() == 0) begin
         $display("** first_fit_memory_resource_allocator: PASSED **");
      end else begin
         $display("** first_fit_memory_resource_allocator: FAILED **");
      end
      $finish;
   end

endmodule
